FILE: hw/rtl/plg_pkg.sv
`default_nettype none

package plg_pkg;

  // Grid geometry.
  localparam int GRID_SIDE  = 3;
  localparam int NODE_TOTAL = GRID_SIDE * GRID_SIDE;
  localparam int NODE_W     = 4;
  localparam int RC_W       = $clog2(GRID_SIDE);
  localparam int PATH_W     = NODE_TOTAL * NODE_W;

  // Field widths.
  localparam int MODE_W     = 3;
  localparam int COORD_W    = 12;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 10;
  localparam int MIN_W      = 4;
  localparam int MARGIN_W   = 5;
  localparam int STEP_W     = 9;
  localparam int CTR_W      = 11;
  localparam int RAD_W      = 7;
  localparam int SQ_W       = 2 * RAD_W;

  // Step size is width / GRID_SIDE, done as a multiply by a rounded-up
  // reciprocal; exact for every 10-bit width.
  localparam int DIV_SH     = 12;
  localparam int DIV_RECIP  = ((1 << DIV_SH) + GRID_SIDE - 1) / GRID_SIDE;
  localparam int DIV_PROD_W = 22;

  localparam logic [NODE_W-1:0]     SLOT_EMPTY  = 4'hF;
  localparam logic [CFG_DATA_W-1:0] MIN_REGION  = 10'd20;
  localparam logic [MARGIN_W-1:0]   MARGIN_MAX  = 5'd24;
  localparam logic [RAD_W-1:0]      RADIUS_MIN  = 7'd4;
  localparam logic [MIN_W-1:0]      MIN_NODES_RST = 4'd4;
  localparam logic [MARGIN_W-1:0]   MARGIN_RST  = 5'd5;

  // Event kinds.
  localparam logic [MODE_W-1:0] MODE_DOWN   = 3'd0;
  localparam logic [MODE_W-1:0] MODE_MOVE   = 3'd1;
  localparam logic [MODE_W-1:0] MODE_UP     = 3'd2;
  localparam logic [MODE_W-1:0] MODE_CANCEL = 3'd3;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_LEFT    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TOP     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_MARGIN  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_ENABLE  = 3'd6;

  typedef struct packed {
    logic [MODE_W-1:0]         mode;
    logic signed [COORD_W-1:0] touch_x;
    logic signed [COORD_W-1:0] touch_y;
  } in_item_t;

  typedef struct packed {
    logic              handled;
    logic              tracking;
    logic              completed;
    logic              pattern_error;
    logic [NODE_W-1:0] node_count;
    logic [PATH_W-1:0] path;
    logic              finish_event;
    logic              complete_event;
  } out_item_t;

endpackage

`default_nettype wire

FILE: hw/rtl/plg_in_if.sv
`default_nettype none

interface plg_in_if import plg_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/plg_out_if.sv
`default_nettype none

interface plg_out_if import plg_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/pattern_lock_gesture_tracker.sv
// Channel   Dir  Handshake          Payload
// in_ch     in   valid / ready      mode, touch_x, touch_y
// out_ch    out  valid / ready      handled, tracking, completed, pattern_error,
//                                   node_count, path, finish_event, complete_event
// cfg_*     in   cfg_we, no stall   cfg_idx selects the register, cfg_wdata the value
//
// Every transaction passes three registers: the input register, the hit register and
// the result register, in that order.
// One transaction is taken per cycle while no stall or settling holds the input register;
// the hit test runs on all nodes in parallel. Reset is synchronous on rst_n; after reset,
// and after every configuration write, the input register holds until the geometry settles.
// A stalled result register backs up into the hit and input registers in turn.
`default_nettype none

module pattern_lock_gesture_tracker import plg_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  plg_in_if.sink                in_ch,
  plg_out_if.source             out_ch
);

  typedef logic [NODE_W-1:0]     slot_t;
  typedef logic [NODE_TOTAL-1:0] mask_t;

  // ---------------------------------------------------------------------------
  // Configuration registers.
  // ---------------------------------------------------------------------------
  logic [CFG_DATA_W-1:0] region_left_r, region_top_r, region_width_r, region_height_r;
  logic [MIN_W-1:0]      min_nodes_r;
  logic [MARGIN_W-1:0]   margin_r;
  logic                  enabled_r;
  logic [1:0]            settle_r;
  logic                  cfg_busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      region_left_r   <= '0;
      region_top_r    <= '0;
      region_width_r  <= '0;
      region_height_r <= '0;
      min_nodes_r     <= MIN_NODES_RST;
      margin_r        <= MARGIN_RST;
      enabled_r       <= 1'b1;
      settle_r        <= 2'd2;
    end else begin
      if (cfg_we) begin
        settle_r <= 2'd2;
        case (cfg_idx)
          CFG_LEFT:   region_left_r   <= cfg_wdata;
          CFG_TOP:    region_top_r    <= cfg_wdata;
          CFG_WIDTH:  region_width_r  <= cfg_wdata;
          CFG_HEIGHT: region_height_r <= cfg_wdata;
          CFG_MIN:    min_nodes_r     <= cfg_wdata[MIN_W-1:0];
          CFG_MARGIN: margin_r        <= cfg_wdata[MARGIN_W-1:0];
          CFG_ENABLE: enabled_r       <= cfg_wdata[0];
          default: ;
        endcase
      end else if (settle_r != 2'd0) begin
        settle_r <= settle_r - 2'd1;
      end
    end
  end

  // The input register may not move on until the geometry below reflects the
  // latest write.
  assign cfg_busy = (settle_r != 2'd0);

  // ---------------------------------------------------------------------------
  // Geometry, first step: grid steps, a small-region flag and the clamped margin.
  // ---------------------------------------------------------------------------
  logic [DIV_PROD_W-1:0] prod_x, prod_y;
  logic [STEP_W-1:0]     sx_r, sy_r;
  logic                  small_r;
  logic [MARGIN_W-1:0]   mgn_r;

  assign prod_x = DIV_PROD_W'(region_width_r)  * DIV_PROD_W'(DIV_RECIP);
  assign prod_y = DIV_PROD_W'(region_height_r) * DIV_PROD_W'(DIV_RECIP);

  always_ff @(posedge clk) begin
    sx_r    <= prod_x[DIV_SH +: STEP_W];
    sy_r    <= prod_y[DIV_SH +: STEP_W];
    small_r <= (region_width_r <= MIN_REGION) || (region_height_r <= MIN_REGION);
    mgn_r   <= (margin_r > MARGIN_MAX) ? MARGIN_MAX : margin_r;
  end

  // ---------------------------------------------------------------------------
  // Geometry, second step: squared hit radius and the node centres, one per
  // column and one per row.
  // ---------------------------------------------------------------------------
  logic [STEP_W-1:0] step_min;
  logic [RAD_W-1:0]  rad_base, rad;
  logic [SQ_W-1:0]   r2_r;
  logic [CTR_W-1:0]  cx_r [GRID_SIDE];
  logic [CTR_W-1:0]  cy_r [GRID_SIDE];
  logic              nohit_r;

  always_comb begin
    step_min = (sx_r < sy_r) ? sx_r : sy_r;
    rad_base = RAD_W'(step_min >> 2);
    if (rad_base < RADIUS_MIN) begin
      rad_base = RADIUS_MIN;
    end
    rad = rad_base + RAD_W'(mgn_r);
  end

  always_ff @(posedge clk) begin
    r2_r    <= SQ_W'(rad) * SQ_W'(rad);
    nohit_r <= small_r;
    for (int c = 0; c < GRID_SIDE; c++) begin
      cx_r[c] <= CTR_W'(region_left_r) + CTR_W'(sx_r >> 1) + CTR_W'(sx_r) * CTR_W'(c);
      cy_r[c] <= CTR_W'(region_top_r)  + CTR_W'(sy_r >> 1) + CTR_W'(sy_r) * CTR_W'(c);
    end
  end

  // ---------------------------------------------------------------------------
  // Pipeline flow control.
  // ---------------------------------------------------------------------------
  logic      s1_v_r, s2_v_r, out_v_r;
  logic      out_free, s2_go, s2_free, s1_go, in_ready, in_take;
  in_item_t  s1_item_r;
  out_item_t out_data_r;

  assign out_free = !out_v_r || out_ch.ready;
  assign s2_go    = s2_v_r && out_free;
  assign s2_free  = !s2_v_r || s2_go;
  assign s1_go    = s1_v_r && !cfg_busy && s2_free;
  assign in_ready = !s1_v_r || s1_go;
  assign in_take  = in_ch.valid && in_ready;

  assign in_ch.ready  = in_ready;
  assign out_ch.valid = out_v_r;
  assign out_ch.data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (in_take) begin
        s1_v_r <= 1'b1;
      end else if (s1_go) begin
        s1_v_r <= 1'b0;
      end
      if (s1_go) begin
        s2_v_r <= 1'b1;
      end else if (s2_go) begin
        s2_v_r <= 1'b0;
      end
      if (s2_go) begin
        out_v_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_item_r <= in_ch.data;
    end
  end

  // ---------------------------------------------------------------------------
  // Hit test. Distances are split by column and by row; a distance of 128 or
  // more on either axis lies beyond the largest possible radius, so the squares
  // only need seven bits of magnitude.
  // ---------------------------------------------------------------------------
  logic signed [COORD_W:0] dx [GRID_SIDE];
  logic signed [COORD_W:0] dy [GRID_SIDE];
  logic [COORD_W-1:0]      adx [GRID_SIDE];
  logic [COORD_W-1:0]      ady [GRID_SIDE];
  logic                    near_x [GRID_SIDE];
  logic                    near_y [GRID_SIDE];
  logic [SQ_W-1:0]         sqx [GRID_SIDE];
  logic [SQ_W-1:0]         sqy [GRID_SIDE];
  logic [SQ_W:0]           dist2;
  logic                    hit_v;
  logic [NODE_W-1:0]       hit_idx;
  logic [RC_W-1:0]         hit_row, hit_col;

  always_comb begin
    for (int c = 0; c < GRID_SIDE; c++) begin
      dx[c]     = {s1_item_r.touch_x[COORD_W-1], s1_item_r.touch_x}
                  - $signed({(COORD_W + 1 - CTR_W)'(1'b0), cx_r[c]});
      dy[c]     = {s1_item_r.touch_y[COORD_W-1], s1_item_r.touch_y}
                  - $signed({(COORD_W + 1 - CTR_W)'(1'b0), cy_r[c]});
      adx[c]    = dx[c][COORD_W] ? COORD_W'(-dx[c]) : COORD_W'(dx[c]);
      ady[c]    = dy[c][COORD_W] ? COORD_W'(-dy[c]) : COORD_W'(dy[c]);
      near_x[c] = (adx[c][COORD_W-1:RAD_W] == '0);
      near_y[c] = (ady[c][COORD_W-1:RAD_W] == '0);
      sqx[c]    = SQ_W'(adx[c][RAD_W-1:0]) * SQ_W'(adx[c][RAD_W-1:0]);
      sqy[c]    = SQ_W'(ady[c][RAD_W-1:0]) * SQ_W'(ady[c][RAD_W-1:0]);
    end

    // Scanned from the highest index down so that the lowest hit wins.
    hit_v   = 1'b0;
    hit_idx = '0;
    hit_row = '0;
    hit_col = '0;
    dist2   = '0;
    for (int r = GRID_SIDE - 1; r >= 0; r--) begin
      for (int c = GRID_SIDE - 1; c >= 0; c--) begin
        dist2 = (SQ_W + 1)'(sqx[c]) + (SQ_W + 1)'(sqy[r]);
        if (!nohit_r && near_x[c] && near_y[r] && (dist2 <= (SQ_W + 1)'(r2_r))) begin
          hit_v   = 1'b1;
          hit_idx = NODE_W'(r * GRID_SIDE + c);
          hit_row = RC_W'(r);
          hit_col = RC_W'(c);
        end
      end
    end
  end

  logic [MODE_W-1:0] s2_mode_r;
  logic              s2_hit_v_r;
  logic [NODE_W-1:0] s2_hit_r;
  logic [RC_W-1:0]   s2_row_r, s2_col_r;

  always_ff @(posedge clk) begin
    if (s1_go) begin
      s2_mode_r  <= s1_item_r.mode;
      s2_hit_v_r <= hit_v;
      s2_hit_r   <= hit_idx;
      s2_row_r   <= hit_row;
      s2_col_r   <= hit_col;
    end
  end

  // ---------------------------------------------------------------------------
  // Gesture state. The last node of the path is kept as a row and column so
  // that the skipped middle node can be found without reading the path back.
  // ---------------------------------------------------------------------------
  slot_t           path_r [NODE_TOTAL];
  slot_t           path_nxt [NODE_TOTAL];
  mask_t           mask_r, mask_nxt, mask1;
  logic [NODE_W-1:0] len_r, len_nxt, len1;
  logic [RC_W-1:0] lrow_r, lcol_r, lrow_nxt, lcol_nxt;
  logic            trk_r, trk_nxt, cmp_r, cmp_nxt, err_r, err_nxt;
  logic            handled, fin, comp;

  logic [RC_W:0]     dr, dc, adr, adc;
  logic [RC_W-1:0]   mid_row, mid_col;
  logic [NODE_W-1:0] mid, min_eff;
  logic              bridge_v, add_mid, add_hit;
  out_item_t         out_nxt;

  always_comb begin
    // Middle node of a straight or diagonal jump of two steps.
    dr       = {1'b0, s2_row_r} - {1'b0, lrow_r};
    dc       = {1'b0, s2_col_r} - {1'b0, lcol_r};
    adr      = dr[RC_W] ? -dr : dr;
    adc      = dc[RC_W] ? -dc : dc;
    mid_row  = RC_W'(({1'b0, s2_row_r} + {1'b0, lrow_r}) >> 1);
    mid_col  = RC_W'(({1'b0, s2_col_r} + {1'b0, lcol_r}) >> 1);
    mid      = NODE_W'(mid_row) * NODE_W'(GRID_SIDE) + NODE_W'(mid_col);
    bridge_v = (len_r != '0)
               && ((adr == (RC_W + 1)'(2)) || (adr == '0))
               && ((adc == (RC_W + 1)'(2)) || (adc == '0))
               && !((adr == '0) && (adc == '0));

    add_mid = bridge_v && !mask_r[mid] && (len_r < NODE_W'(NODE_TOTAL));
    mask1   = add_mid ? (mask_r | (mask_t'(1) << mid)) : mask_r;
    len1    = len_r + NODE_W'(add_mid);
    add_hit = !mask1[s2_hit_r] && (len1 < NODE_W'(NODE_TOTAL));

    // The release threshold is read as clamped to one node at least and one full path at most.
    if (min_nodes_r == '0) begin
      min_eff = NODE_W'(1);
    end else if (min_nodes_r > NODE_W'(NODE_TOTAL)) begin
      min_eff = NODE_W'(NODE_TOTAL);
    end else begin
      min_eff = min_nodes_r;
    end

    path_nxt = path_r;
    mask_nxt = mask_r;
    len_nxt  = len_r;
    lrow_nxt = lrow_r;
    lcol_nxt = lcol_r;
    trk_nxt  = trk_r;
    cmp_nxt  = cmp_r;
    err_nxt  = err_r;
    handled  = 1'b0;
    fin      = 1'b0;
    comp     = 1'b0;

    if (enabled_r) begin
      case (s2_mode_r)
        MODE_DOWN: begin
          for (int k = 0; k < NODE_TOTAL; k++) begin
            path_nxt[k] = SLOT_EMPTY;
          end
          mask_nxt = '0;
          len_nxt  = '0;
          trk_nxt  = 1'b0;
          cmp_nxt  = 1'b0;
          err_nxt  = 1'b0;
          if (s2_hit_v_r) begin
            path_nxt[0] = s2_hit_r;
            mask_nxt    = mask_t'(1) << s2_hit_r;
            len_nxt     = NODE_W'(1);
            lrow_nxt    = s2_row_r;
            lcol_nxt    = s2_col_r;
            trk_nxt     = 1'b1;
            handled     = 1'b1;
          end
        end
        MODE_MOVE, MODE_UP: begin
          if (trk_r) begin
            handled = 1'b1;
            if (s2_hit_v_r && !mask_r[s2_hit_r]) begin
              for (int k = 0; k < NODE_TOTAL; k++) begin
                if (add_mid && (len_r == NODE_W'(k))) begin
                  path_nxt[k] = mid;
                end else if (add_hit && (len1 == NODE_W'(k))) begin
                  path_nxt[k] = s2_hit_r;
                end
              end
              mask_nxt = add_hit ? (mask1 | (mask_t'(1) << s2_hit_r)) : mask1;
              len_nxt  = len1 + NODE_W'(add_hit);
              if (add_hit) begin
                lrow_nxt = s2_row_r;
                lcol_nxt = s2_col_r;
              end else if (add_mid) begin
                lrow_nxt = mid_row;
                lcol_nxt = mid_col;
              end
            end
            if (s2_mode_r == MODE_UP) begin
              trk_nxt = 1'b0;
              cmp_nxt = 1'b1;
              err_nxt = (len_nxt < min_eff);
              fin     = 1'b1;
              comp    = !err_nxt;
            end
          end
        end
        MODE_CANCEL: begin
          for (int k = 0; k < NODE_TOTAL; k++) begin
            path_nxt[k] = SLOT_EMPTY;
          end
          mask_nxt = '0;
          len_nxt  = '0;
          trk_nxt  = 1'b0;
          cmp_nxt  = 1'b0;
          err_nxt  = 1'b0;
          handled  = 1'b1;
        end
        default: ;
      endcase
    end

    out_nxt.handled        = handled;
    out_nxt.tracking       = trk_nxt;
    out_nxt.completed      = cmp_nxt;
    out_nxt.pattern_error  = err_nxt;
    out_nxt.node_count     = len_nxt;
    out_nxt.finish_event   = fin;
    out_nxt.complete_event = comp;
    out_nxt.path           = '0;
    for (int k = 0; k < NODE_TOTAL; k++) begin
      out_nxt.path[k * NODE_W +: NODE_W] = path_nxt[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NODE_TOTAL; k++) begin
        path_r[k] <= SLOT_EMPTY;
      end
      mask_r <= '0;
      len_r  <= '0;
      lrow_r <= '0;
      lcol_r <= '0;
      trk_r  <= 1'b0;
      cmp_r  <= 1'b0;
      err_r  <= 1'b0;
    end else if (s2_go) begin
      path_r <= path_nxt;
      mask_r <= mask_nxt;
      len_r  <= len_nxt;
      lrow_r <= lrow_nxt;
      lcol_r <= lcol_nxt;
      trk_r  <= trk_nxt;
      cmp_r  <= cmp_nxt;
      err_r  <= err_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_go) begin
      out_data_r <= out_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/plg_checker.sv
`default_nettype none

module plg_checker import plg_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_data
);

  // A stalled result holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // A completion is always a finish without an error.
  a_complete: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.complete_event |->
      out_data.finish_event && !out_data.pattern_error)
    else $error("complete event without a clean finish");

  // A finish is handled and leaves the gesture completed and no longer tracked.
  a_finish: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.finish_event |->
      out_data.completed && !out_data.tracking && out_data.handled)
    else $error("finish event with inconsistent flags");

  // A tracked gesture always holds at least one node, never more than the grid.
  a_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.node_count <= NODE_W'(NODE_TOTAL))
      && (!out_data.tracking || (out_data.node_count != '0)))
    else $error("node count out of range");

endmodule

bind pattern_lock_gesture_tracker plg_checker u_plg_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_data  (out_ch.data)
);

`default_nettype wire
